/* hw/rtl/sequential_list_engine_macros.svh */
// Assertion macros shared by the sequential list engine RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sle_pkg.sv */
// Package for the sequential list engine: operation and status codes,
// controller states and the control word that drives every list cell.
`timescale 1ns / 1ps

package sle_pkg;

  // Wide enough for any position or length up to 127.
  localparam int unsigned PosW      = 7;
  localparam int unsigned DumpLimit = 16;

  typedef enum logic [2:0] {
    OpPushBack  = 3'd0,
    OpPopBack   = 3'd1,
    OpPushFront = 3'd2,
    OpPopFront  = 3'd3,
    OpInsertAt  = 3'd4,
    OpEraseAt   = 3'd5,
    OpFind      = 3'd6,
    OpDump      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatIgnored = 2'd1,
    StatFull    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellErase,
    CellRotate
  } cell_cmd_e;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [PosW-1:0]  pos;
  } cell_ctrl_t;

endpackage

/* hw/rtl/sle_cell.sv */
// One storage cell of the list chain: holds a single word and takes it from
// itself, its left or right neighbor, or the input value. Uses sle_pkg.
`timescale 1ns / 1ps

module sle_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  sle_pkg::cell_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  word_o
);
  import sle_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

  logic [DATA_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.cmd)
      CellInsert: begin
        if (MyIdx == ctrl_i.pos) begin
          word_d = value_i;
        end else if (MyIdx > ctrl_i.pos) begin
          word_d = left_i;
        end
      end
      CellErase: begin
        if (MyIdx >= ctrl_i.pos) begin
          word_d = right_i;
        end
      end
      CellRotate: begin
        word_d = right_i;
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* hw/rtl/sequential_list_engine.sv */
// Top level of the sequential list engine: command decode, scan sequencer,
// result registers and the chain of sle_cell storage cells. Uses sle_pkg.
`timescale 1ns / 1ps
`include "sequential_list_engine_macros.svh"

// The block keeps a packed list of up to CAPACITY signed words and its length.
// A command item is taken at a rising edge where start_i is high and busy_o is
// low; op_i selects push or pop at either end, insert or erase at position_i,
// find of value_i, or dump of the whole list.
// Each result item is shown for exactly one cycle with result_valid_o high, and
// last_o marks the final result of a command. The receiver cannot stall, so no
// result is ever held back or repeated.
// Push, pop, insert and erase need no scan: every cell decides from its
// own index and the position whether to hold, load or take a neighbor's word,
// and the single result appears in the cycle after the command is taken. Such
// commands may be issued in every cycle while busy_o is low.
// Find and dump on a non-empty list rotate the cell chain once around, one
// place per cycle, and read the head cell; busy_o stays high for the whole
// rotation. Dump emits one result per stored word (at most sixteen) in
// consecutive cycles, find emits one result as soon as it sees the first match
// or the end of the list. On an empty list both answer in the next cycle.
// Reset clears the length and the controller; the stored words are not
// cleared and are never read beyond the current length.
module sequential_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          op_i,
  input  logic signed [31:0]  value_i,
  input  logic [4:0]          position_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic                found_o,
  output logic [3:0]          index_o,
  output logic signed [31:0]  element_o,
  output logic [4:0]          count_o,
  output logic                last_o
);
  import sle_pkg::*;

  localparam int unsigned LenW  = $clog2(CAPACITY + 1);
  localparam int unsigned StepW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(CAPACITY - 1);
  localparam logic [LenW-1:0]  CapLen   = LenW'(CAPACITY);

  // Controller state.
  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              dump_q, dump_d;
  logic              emitted_q, emitted_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;

  // Result registers.
  logic              rv_q, rv_d;
  logic [1:0]        status_q, status_d;
  logic              found_q, found_d;
  logic [3:0]        index_q, index_d;
  logic signed [31:0] element_q, element_d;
  logic [4:0]        count_q, count_d;
  logic              last_q, last_d;

  logic              accept;
  logic              scanning;
  logic              go_scan;
  cell_ctrl_t        ctrl;
  logic [DATA_WIDTH-1:0] val_w;
  logic [DATA_WIDTH-1:0] head;
  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic [PosW-1:0]   len_ext, pos_ext, step_ext, dump_n;
  logic              is_ins, is_era;
  logic [PosW-1:0]   tgt_pos;
  status_e           stat;
  logic              match;

  assign val_w    = DATA_WIDTH'(value_i);
  assign len_ext  = PosW'(len_q);
  assign pos_ext  = PosW'(position_i);
  assign step_ext = PosW'(step_q);
  assign dump_n   = (len_ext < PosW'(DumpLimit)) ? len_ext : PosW'(DumpLimit);
  assign head     = words[0];
  assign match    = (head == key_q);
  assign accept   = start_i && !busy_o;

  // Next-state logic of the controller.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && go_scan) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (step_q == LastStep) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output logic of the controller.
  always_comb begin
    busy_o   = 1'b0;
    scanning = 1'b0;
    case (state_q)
      StIdle: begin
        busy_o   = 1'b0;
        scanning = 1'b0;
      end
      StScan: begin
        busy_o   = 1'b1;
        scanning = 1'b1;
      end
      default: begin
        busy_o   = 1'b0;
        scanning = 1'b0;
      end
    endcase
  end

  // Command decode: pick the insert or erase position, or flag a find/dump scan.
  always_comb begin
    is_ins  = 1'b0;
    is_era  = 1'b0;
    tgt_pos = '0;
    go_scan = 1'b0;
    case (op_e'(op_i))
      OpPushBack: begin
        is_ins  = 1'b1;
        tgt_pos = len_ext;
      end
      OpPopBack: begin
        // An empty list wraps this to all ones, which reads as out of range.
        is_era  = 1'b1;
        tgt_pos = len_ext - PosW'(1);
      end
      OpPushFront: begin
        is_ins  = 1'b1;
      end
      OpPopFront: begin
        is_era  = 1'b1;
      end
      OpInsertAt: begin
        is_ins  = 1'b1;
        tgt_pos = pos_ext;
      end
      OpEraseAt: begin
        is_era  = 1'b1;
        tgt_pos = pos_ext;
      end
      OpFind, OpDump: begin
        go_scan = (len_q != '0);
      end
      default: begin
        go_scan = 1'b0;
      end
    endcase
  end

  // Datapath: cell control, length update and result formation.
  always_comb begin
    ctrl      = '{cmd: CellHold, pos: '0};
    len_d     = len_q;
    step_d    = step_q;
    dump_d    = dump_q;
    emitted_d = emitted_q;
    key_d     = key_q;
    stat      = StatDone;
    rv_d      = 1'b0;
    status_d  = StatDone;
    found_d   = 1'b0;
    index_d   = '0;
    element_d = '0;
    count_d   = 5'(len_q);
    last_d    = 1'b1;

    if (scanning) begin
      ctrl.cmd = CellRotate;
      step_d   = step_q + StepW'(1);
      if (dump_q) begin
        if (step_ext < dump_n) begin
          rv_d      = 1'b1;
          found_d   = 1'b1;
          index_d   = 4'(step_q);
          element_d = 32'($signed(head));
          last_d    = (step_ext + PosW'(1) == dump_n);
        end
      end else if (!emitted_q && (step_ext < len_ext) &&
                   (match || (step_ext == len_ext - PosW'(1)))) begin
        rv_d      = 1'b1;
        found_d   = match;
        index_d   = match ? 4'(step_q) : 4'd0;
        emitted_d = 1'b1;
      end
    end else if (accept) begin
      step_d    = '0;
      dump_d    = (op_e'(op_i) == OpDump);
      emitted_d = 1'b0;
      key_d     = val_w;
      if (is_ins) begin
        // Position is checked before fullness.
        if (tgt_pos > len_ext) begin
          stat = StatIgnored;
        end else if (len_q == CapLen) begin
          stat = StatFull;
        end else begin
          ctrl  = '{cmd: CellInsert, pos: tgt_pos};
          len_d = len_q + LenW'(1);
        end
      end else if (is_era) begin
        if (tgt_pos >= len_ext) begin
          stat = StatIgnored;
        end else begin
          ctrl  = '{cmd: CellErase, pos: tgt_pos};
          len_d = len_q - LenW'(1);
        end
      end
      // Every command except a scan of a non-empty list answers at once.
      rv_d     = !go_scan;
      status_d = stat;
      count_d  = 5'(len_d);
    end
  end

  // Chain of cells; the last cell's right neighbor is the head, so a full
  // rotation brings the list back to its original order.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    if (i == 0) begin : g_head
      assign left_w = words[0];
    end else begin : g_body
      assign left_w = words[i-1];
    end
    sle_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (val_w),
      .left_i  (left_w),
      .right_i (words[(i + 1) % CAPACITY]),
      .word_o  (words[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      len_q     <= '0;
      step_q    <= '0;
      dump_q    <= 1'b0;
      emitted_q <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      step_q    <= step_d;
      dump_q    <= dump_d;
      emitted_q <= emitted_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    status_q  <= status_d;
    found_q   <= found_d;
    index_q   <= index_d;
    element_q <= element_d;
    count_q   <= count_d;
    last_q    <= last_d;
  end

  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign index_o        = index_q;
  assign element_o      = element_q;
  assign count_o        = count_q;
  assign last_o         = last_q;

  // The length never exceeds the number of cells.
  `SLE_ASSERT(a_len_bound, 1'b1, len_q <= CapLen, "list length exceeds capacity")
  // A scan never changes the length.
  `SLE_ASSERT_NEXT(a_scan_len, scanning, len_q == $past(len_q), "length changed during scan")
  // A command that needs no scan answers with one final result in the next cycle.
  `SLE_ASSERT_NEXT(a_single_result, accept && !go_scan, rv_q && last_q, "missing single result")
  // A find scan has emitted its result by the time the rotation completes.
  `SLE_ASSERT_NEXT(a_find_done, scanning && !dump_q && step_q == LastStep, emitted_q,
                   "find scan ended without a result")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the sequential list engine.
// Depends on sle_pkg and the sequential_list_engine top level; nothing else.
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned RandomItems = 350;
  localparam int unsigned QuietTail   = 50;

  // One result item as the block shows it on its result ports.
  typedef struct {
    status_e            status;
    logic               found;
    logic [3:0]         index;
    logic signed [31:0] element;
    logic [4:0]         count;
    logic               last;
  } list_result_t;

  // The scoreboard keeps its own copy of the list. Every accepted command is
  // applied to that copy at once, and the results it must cause are queued in
  // order. Each result the block shows is checked against the oldest one.
  class list_scoreboard;
    logic signed [31:0] words [Capacity];
    int unsigned        len;
    list_result_t       awaited [$];
    int unsigned        errors;

    function new();
      len    = 0;
      errors = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // Opens a slot at the given place and shifts the tail back by one.
    function status_e put_word(int unsigned at, logic signed [31:0] w);
      if (at > len) return StatIgnored;
      if (len >= Capacity) return StatFull;
      for (int unsigned i = len; i > at; i--) words[i] = words[i - 1];
      words[at] = w;
      len++;
      return StatDone;
    endfunction

    // Closes the slot at the given place and pulls the tail forward by one.
    function status_e take_word(int unsigned at);
      if (at >= len) return StatIgnored;
      for (int unsigned i = at; i + 1 < len; i++) words[i] = words[i + 1];
      len--;
      return StatDone;
    endfunction

    function void queue_result(status_e st, logic fnd, int unsigned idx,
                               logic signed [31:0] el, logic lst);
      list_result_t r;
      r.status  = st;
      r.found   = fnd;
      r.index   = 4'(idx);
      r.element = el;
      r.count   = 5'(len);
      r.last    = lst;
      awaited.push_back(r);
    endfunction

    function void note_command(op_e op, logic signed [31:0] v, logic [4:0] pos);
      status_e     st;
      int unsigned n;
      case (op)
        OpPushBack:  st = put_word(len, v);
        OpPopBack:   st = (len > 0) ? take_word(len - 1) : StatIgnored;
        OpPushFront: st = put_word(0, v);
        OpPopFront:  st = take_word(0);
        OpInsertAt:  st = put_word(pos, v);
        OpEraseAt:   st = take_word(pos);
        OpFind: begin
          for (int unsigned i = 0; i < len; i++) begin
            if (words[i] == v) begin
              queue_result(StatDone, 1'b1, i, '0, 1'b1);
              return;
            end
          end
          queue_result(StatDone, 1'b0, 0, '0, 1'b1);
          return;
        end
        default: begin
          // Dump: one result per stored word, at most DumpLimit, or one empty result.
          if (len == 0) begin
            queue_result(StatDone, 1'b0, 0, '0, 1'b1);
          end else begin
            n = (len < DumpLimit) ? len : DumpLimit;
            for (int unsigned i = 0; i < n; i++) begin
              queue_result(StatDone, 1'b1, i, words[i], i + 1 == n);
            end
          end
          return;
        end
      endcase
      queue_result(st, 1'b0, 0, '0, 1'b1);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic [1:0] status, logic found, logic [3:0] index,
                               logic signed [31:0] element, logic [4:0] count,
                               logic last);
      list_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                 $time, status, count);
        return;
      end
      e = awaited.pop_front();
      compare("status", e.status, status);
      compare("found", e.found, found);
      compare("index", e.index, index);
      compare("element", e.element, element);
      compare("count", e.count, count);
      compare("last", e.last, last);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  // Every input starts at a known value; reset is held low from time zero.
  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic [2:0]         op_i       = '0;
  logic signed [31:0] value_i    = '0;
  logic [4:0]         position_i = '0;
  logic               busy_o;
  logic               result_valid_o;
  logic [1:0]         status_o;
  logic               found_o;
  logic [3:0]         index_o;
  logic signed [31:0] element_o;
  logic [4:0]         count_o;
  logic               last_o;

  list_scoreboard sb = new();

  sequential_list_engine #(
    .CAPACITY  (Capacity),
    .DATA_WIDTH(32)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .found_o       (found_o),
    .index_o       (index_o),
    .element_o     (element_o),
    .count_o       (count_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results cannot be held off, so every strobe seen at a rising edge is one
  // accepted result item. Values read here are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_result(status_o, found_o, index_o, element_o, count_o, last_o);
    end
  end

  // Presents one command item and holds it until an edge where busy_o is low.
  // start_i stays high on return, so a back-to-back item is driven in the same
  // step with a single assignment to each signal.
  task automatic issue(op_e op, logic signed [31:0] v, logic [4:0] pos);
    start_i    <= 1'b1;
    op_i       <= op;
    value_i    <= v;
    position_i <= pos;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(op, v, pos);
  endtask

  // Sender idle burst. The command fields carry junk that must be ignored.
  task automatic rest(int unsigned cycles);
    start_i    <= 1'b0;
    op_i       <= 3'($urandom_range(0, 7));
    value_i    <= $urandom();
    position_i <= 5'($urandom_range(0, 31));
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds the sender back until every predicted result has been seen or the limit runs out.
  task automatic drain(int unsigned limit);
    start_i <= 1'b0;
    for (int unsigned c = 0; c < limit && sb.pending() != 0; c++) @(posedge clk_i);
  endtask

  // Two values in five come from a tiny pool so that find hits and the list
  // holds duplicates, with the sign extremes and fully random words mixed in.
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return $urandom_range(0, 6) - 3;
    if (r < 11) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  // The op mix follows the current trend so the length sweeps from empty to
  // full and back again, spending time at both ends.
  function automatic op_e pick_op(bit growing);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (growing) begin
      if (r < 30) return OpPushBack;
      if (r < 48) return OpPushFront;
      if (r < 66) return OpInsertAt;
      if (r < 72) return OpPopBack;
      if (r < 76) return OpPopFront;
      if (r < 82) return OpEraseAt;
      if (r < 92) return OpFind;
      return OpDump;
    end
    if (r < 8)  return OpPushBack;
    if (r < 12) return OpPushFront;
    if (r < 18) return OpInsertAt;
    if (r < 36) return OpPopBack;
    if (r < 54) return OpPopFront;
    if (r < 78) return OpEraseAt;
    if (r < 90) return OpFind;
    return OpDump;
  endfunction

  initial begin : stimulus
    op_e                op;
    logic signed [31:0] v;
    logic [4:0]         pos;
    bit                 growing;
    bit                 idle_on;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. First every way an empty list can refuse or answer.
    issue(OpDump, '0, '0);
    issue(OpFind, '0, '0);
    issue(OpPopBack, '0, '0);
    issue(OpPopFront, '0, '0);
    issue(OpEraseAt, '0, '0);
    issue(OpInsertAt, 32'sd5, 5'd1);

    // Build a short list from both ends and the middle, with the word extremes.
    issue(OpPushBack, 32'sh7fffffff, '0);
    issue(OpPushFront, 32'sh80000000, '0);
    issue(OpInsertAt, -1, 5'd1);
    issue(OpInsertAt, '0, 5'd3);
    issue(OpEraseAt, '0, 5'd4);
    issue(OpFind, -1, '0);
    issue(OpFind, 32'sd12345, '0);
    issue(OpDump, '0, '0);

    // Fill to capacity, then hit the full list at the back and by position. A
    // position past the length must be ignored even though the list is also full.
    for (int k = 0; k < 12; k++) issue(OpPushBack, k - 6, '0);
    issue(OpPushBack, 32'sd99, '0);
    issue(OpInsertAt, 32'sd99, 5'd17);
    issue(OpInsertAt, 32'sd99, 5'd31);
    issue(OpInsertAt, 32'sd99, 5'd16);
    issue(OpFind, '0, '0);
    issue(OpDump, '0, '0);

    // Random part.
    growing = 1'b0;
    idle_on = 1'b1;
    for (int unsigned k = 0; k < RandomItems; k++) begin
      if (sb.len == Capacity && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (sb.len == 0 && $urandom_range(0, 1) == 0) growing = 1'b1;
      if ($urandom_range(0, 39) == 0) growing = !growing;
      if (k % 40 == 0) idle_on = $urandom_range(0, 1);

      op  = pick_op(growing);
      v   = pick_value();
      pos = 5'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 85) begin
        if (op == OpInsertAt) pos = 5'($urandom_range(0, sb.len));
        if (op == OpEraseAt && sb.len > 0) pos = 5'($urandom_range(0, sb.len - 1));
      end
      if (op == OpFind && sb.len > 0 && $urandom_range(0, 1) == 0) begin
        v = sb.words[$urandom_range(0, sb.len - 1)];
      end

      // Halfway through, let the block run completely dry once.
      if (k == RandomItems / 2) drain(5000);

      issue(op, v, pos);

      if (k < RandomItems - QuietTail && idle_on && $urandom_range(0, 4) == 0) begin
        rest($urandom_range(1, 13));
      end
    end

    // Wait for the outstanding results, then long enough for a full scan to
    // show any result that should not be there.
    drain(5000);
    repeat (Capacity + 4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results missing: expected %0d more, actual 0", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sequential_list_engine.sv
tb/sv/tb.sv
